>>> design/icb_pkg.sv
// shared constants, command codes, state type and control structs for the counter bank
`timescale 1ns / 1ps

package icb_pkg;

    // default bank depth and readout cap
    localparam int NUM_COUNTERS_DEF = 16;
    localparam int RESULT_CAP       = 16;

    // field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int TS_W    = 64;
    localparam int LIMIT_W = 32;
    localparam int SHIFT_W = 7;

    // largest common shift, every total is zero after it
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 7'd64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STOP_DIFF,
        ST_STOP_WR,
        ST_MAX,
        ST_SCALE,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } state_t;

    // counter memory access enables
    typedef struct packed {
        logic rd_en;
        logic stamp_wr;
        logic stamp_clr;
        logic total_wr;
    } mem_ctl_t;

    // scale unit controls
    typedef struct packed {
        logic clear;
        logic sample;
        logic start;
    } scale_ctl_t;

    // address width of a bank of n counters
    function automatic int addr_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> design/icb_counter_mem.sv
// start stamp and total memories with per-entry valid bits, one shared address
`timescale 1ns / 1ps

module icb_counter_mem #(
    parameter int NUM_COUNTERS = icb_pkg::NUM_COUNTERS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  icb_pkg::mem_ctl_t                             ctl,
    input  logic [icb_pkg::addr_width(NUM_COUNTERS)-1:0]  addr,
    input  logic [icb_pkg::TS_W-1:0]                      stamp_wdata,
    input  logic [icb_pkg::TS_W-1:0]                      total_wdata,
    output logic [icb_pkg::TS_W-1:0]                      stamp_rdata,
    output logic [icb_pkg::TS_W-1:0]                      total_rdata
);
    import icb_pkg::*;

    logic [TS_W-1:0]         stamp_mem [NUM_COUNTERS];
    logic [TS_W-1:0]         total_mem [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] stamp_vld_reg;
    logic [NUM_COUNTERS-1:0] total_vld_reg;
    logic [TS_W-1:0]         stamp_q_reg;
    logic [TS_W-1:0]         total_q_reg;
    logic                    stamp_hit_reg;
    logic                    total_hit_reg;

    // memory writes
    always_ff @(posedge clk)
    begin
        if (ctl.stamp_wr)
        begin
            stamp_mem[addr] <= stamp_wdata;
        end
        if (ctl.total_wr)
        begin
            total_mem[addr] <= total_wdata;
        end
    end

    // registered memory reads
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            stamp_q_reg <= stamp_mem[addr];
            total_q_reg <= total_mem[addr];
        end
    end

    // valid bits, cleared by reset so unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_vld_reg <= '0;
            total_vld_reg <= '0;
            stamp_hit_reg <= 1'b0;
            total_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.stamp_wr)
            begin
                stamp_vld_reg[addr] <= 1'b1;
            end
            else if (ctl.stamp_clr)
            begin
                stamp_vld_reg[addr] <= 1'b0;
            end
            if (ctl.total_wr)
            begin
                total_vld_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                stamp_hit_reg <= stamp_vld_reg[addr];
                total_hit_reg <= total_vld_reg[addr];
            end
        end
    end

    // invalid entries read as zero
    assign stamp_rdata = stamp_hit_reg ? stamp_q_reg : '0;
    assign total_rdata = total_hit_reg ? total_q_reg : '0;

endmodule

>>> design/icb_scale.sv
// running maximum of totals and iterative search for the common right shift
`timescale 1ns / 1ps

module icb_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  icb_pkg::scale_ctl_t         ctl,
    input  logic [icb_pkg::TS_W-1:0]    sample,
    input  logic [icb_pkg::LIMIT_W-1:0] limit,
    output logic                        done,
    output logic [icb_pkg::SHIFT_W-1:0] shift
);
    import icb_pkg::*;

    logic [TS_W-1:0]    largest_reg;
    logic [TS_W-1:0]    work_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               busy_reg;
    logic               more;

    // one shift step per cycle while the value is above the limit and the shift is below SHIFT_MAX
    assign more = (work_reg > {{(TS_W-LIMIT_W){1'b0}}, limit}) && (shift_reg != SHIFT_MAX);
    assign done = busy_reg && !more;
    assign shift = shift_reg;

    // search busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // maximum tracking and shift search datapath
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            largest_reg <= '0;
        end
        else if (ctl.sample && (sample > largest_reg))
        begin
            largest_reg <= sample;
        end
        if (ctl.start)
        begin
            work_reg  <= largest_reg;
            shift_reg <= '0;
        end
        else if (busy_reg && more)
        begin
            work_reg  <= work_reg >> 1;
            shift_reg <= shift_reg + 1'b1;
        end
    end

endmodule

>>> design/icb_ctrl.sv
// command sequencer: start stamp write, stop read-modify-write, readout sweeps and result register
`timescale 1ns / 1ps

module icb_ctrl #(
    parameter int NUM_COUNTERS = icb_pkg::NUM_COUNTERS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          item_valid,
    output logic                                          item_stall,
    input  logic [icb_pkg::CMD_W-1:0]                     command,
    input  logic [icb_pkg::IDX_W-1:0]                     counter_index,
    input  logic [icb_pkg::TS_W-1:0]                      timestamp,
    output logic                                          result_valid,
    input  logic                                          result_stall,
    output logic [icb_pkg::IDX_W-1:0]                     result_index,
    output logic [icb_pkg::LIMIT_W-1:0]                   scaled_total,
    output logic [icb_pkg::SHIFT_W-1:0]                   shift_amount,
    output logic                                          last,
    output icb_pkg::mem_ctl_t                             mem_ctl,
    output logic [icb_pkg::addr_width(NUM_COUNTERS)-1:0]  mem_addr,
    output logic [icb_pkg::TS_W-1:0]                      stamp_wdata,
    output logic [icb_pkg::TS_W-1:0]                      total_wdata,
    input  logic [icb_pkg::TS_W-1:0]                      stamp_rdata,
    input  logic [icb_pkg::TS_W-1:0]                      total_rdata,
    output icb_pkg::scale_ctl_t                           scale_ctl,
    input  logic                                          scale_done,
    input  logic [icb_pkg::SHIFT_W-1:0]                   scale_shift
);
    import icb_pkg::*;

    localparam int AW   = addr_width(NUM_COUNTERS);
    localparam int CW   = $clog2(NUM_COUNTERS + 1);
    localparam int NOUT = (NUM_COUNTERS < RESULT_CAP) ? NUM_COUNTERS : RESULT_CAP;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      idx_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [TS_W-1:0]    diff_reg;
    logic               result_valid_reg;
    logic [IDX_W-1:0]   result_index_reg;
    logic [LIMIT_W-1:0] scaled_total_reg;
    logic [SHIFT_W-1:0] shift_amount_reg;
    logic               last_reg;
    logic               accept;
    logic               in_range;
    logic               sweep_end;
    logic               emit_last;
    logic               slot_free;
    logic               load_out;

    // input handshake and decode
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign in_range   = (int'(counter_index) < NUM_COUNTERS);
    assign sweep_end  = (cnt_reg == CW'(NUM_COUNTERS)) && !pend_reg;
    assign emit_last  = (cnt_reg == CW'(NOUT - 1));
    assign slot_free  = !result_valid_reg || !result_stall;

    // write data: new stamp from the beat, total plus elapsed time
    assign stamp_wdata = timestamp;
    assign total_wdata = total_rdata + diff_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_STOP) && in_range)
                begin
                    state_next = ST_STOP_DIFF;
                end
                else if (accept && (command == CMD_READ))
                begin
                    state_next = ST_MAX;
                end
            end
            ST_STOP_DIFF: state_next = ST_STOP_WR;
            ST_STOP_WR:   state_next = ST_IDLE;
            ST_MAX:
            begin
                if (sweep_end)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (scale_done)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (slot_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        mem_ctl   = '0;
        mem_addr  = cnt_reg[AW-1:0];
        scale_ctl = '0;
        cnt_next  = cnt_reg;
        pend_next = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mem_addr         = AW'(counter_index);
                mem_ctl.stamp_wr = accept && (command == CMD_START) && in_range;
                mem_ctl.rd_en    = accept && (command == CMD_STOP) && in_range;
                if (accept && (command == CMD_READ))
                begin
                    scale_ctl.clear = 1'b1;
                    cnt_next        = '0;
                end
            end
            ST_STOP_DIFF:
            begin
                mem_addr = idx_reg;
            end
            ST_STOP_WR:
            begin
                mem_addr          = idx_reg;
                mem_ctl.total_wr  = 1'b1;
                mem_ctl.stamp_clr = 1'b1;
            end
            ST_MAX:
            begin
                mem_ctl.rd_en    = (cnt_reg < CW'(NUM_COUNTERS));
                pend_next        = mem_ctl.rd_en;
                scale_ctl.sample = pend_reg;
                scale_ctl.start  = sweep_end;
                if (mem_ctl.rd_en)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (sweep_end)
                begin
                    cnt_next = '0;
                end
            end
            ST_SCALE:
            begin
                cnt_next = '0;
            end
            ST_EMIT_RD:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            ST_EMIT_WAIT:
            begin
                load_out = slot_free;
                if (slot_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // beat capture and elapsed time
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= AW'(counter_index);
            ts_reg  <= timestamp;
        end
        if (state_reg == ST_STOP_DIFF)
        begin
            diff_reg <= ts_reg - stamp_rdata;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_index_reg <= IDX_W'(cnt_reg);
            scaled_total_reg <= (scale_shift >= SHIFT_MAX) ? '0
                                : LIMIT_W'(total_rdata >> scale_shift);
            shift_amount_reg <= scale_shift;
            last_reg         <= emit_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_index = result_index_reg;
    assign scaled_total = scaled_total_reg;
    assign shift_amount = shift_amount_reg;
    assign last         = last_reg;

endmodule

>>> design/interval_counter_bank_core.sv
// interval counter bank: start writes the stamp; stop reads, subtracts the elapsed time and adds it
// in the write-back; read: max sweep over the total memory, then a one-bit shift search, then a read
// and an output step per result through the single memory read port
// one item at a time; results leave through an output register that may still wait while the next
// item is accepted. reset clears the per-entry valid bits so every counter reads zero, and sets
// scale_limit to all ones; no clearing pass is needed
`timescale 1ns / 1ps

module interval_counter_bank_core #(
    parameter int NUM_COUNTERS = icb_pkg::NUM_COUNTERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [icb_pkg::LIMIT_W-1:0] scale_limit,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [icb_pkg::CMD_W-1:0]   command,
    input  logic [icb_pkg::IDX_W-1:0]   counter_index,
    input  logic [icb_pkg::TS_W-1:0]    timestamp,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [icb_pkg::IDX_W-1:0]   result_index,
    output logic [icb_pkg::LIMIT_W-1:0] scaled_total,
    output logic [icb_pkg::SHIFT_W-1:0] shift_amount,
    output logic                        last
);
    import icb_pkg::*;

    localparam int AW   = addr_width(NUM_COUNTERS);
    localparam int NOUT = (NUM_COUNTERS < RESULT_CAP) ? NUM_COUNTERS : RESULT_CAP;

    logic [LIMIT_W-1:0] scale_limit_reg;
    mem_ctl_t           mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [TS_W-1:0]    stamp_wdata;
    logic [TS_W-1:0]    total_wdata;
    logic [TS_W-1:0]    stamp_rdata;
    logic [TS_W-1:0]    total_rdata;
    scale_ctl_t         scale_ctl;
    logic               scale_done;
    logic [SHIFT_W-1:0] scale_shift;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_limit_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_limit_reg <= scale_limit;
        end
    end

    // counter storage
    icb_counter_mem #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (mem_ctl),
        .addr        (mem_addr),
        .stamp_wdata (stamp_wdata),
        .total_wdata (total_wdata),
        .stamp_rdata (stamp_rdata),
        .total_rdata (total_rdata)
    );

    // maximum and shift search
    icb_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scale_ctl),
        .sample (total_rdata),
        .limit  (scale_limit_reg),
        .done   (scale_done),
        .shift  (scale_shift)
    );

    // command sequencer
    icb_ctrl #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .counter_index (counter_index),
        .timestamp     (timestamp),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_index  (result_index),
        .scaled_total  (scaled_total),
        .shift_amount  (shift_amount),
        .last          (last),
        .mem_ctl       (mem_ctl),
        .mem_addr      (mem_addr),
        .stamp_wdata   (stamp_wdata),
        .total_wdata   (total_wdata),
        .stamp_rdata   (stamp_rdata),
        .total_rdata   (total_rdata),
        .scale_ctl     (scale_ctl),
        .scale_done    (scale_done),
        .scale_shift   (scale_shift)
    );

`ifndef NO_ASSERTIONS
    // last beat of a readout carries the last emitted counter index
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> result_index == IDX_W'(NOUT - 1))
        else $error("last flag on wrong counter index");

    // common shift never exceeds the full word width
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> shift_amount <= SHIFT_MAX)
        else $error("shift amount out of range");

    // an accepted read command stalls the input side as the sweep begins
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && command == CMD_READ |=> item_stall)
        else $error("input taken during readout sweep");

    // while a readout is short of its last beat the input side stays stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> item_stall)
        else $error("readout ended before last result");
`endif

endmodule
